>>> hw/rtl/fcte_pkg.sv
// package for the cluster table engine: codes, control word and microcode program
`timescale 1ns / 1ps
package fcte_pkg;

  // table geometry and entry codes
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int ENTRY_W           = 28;
  localparam int TOTAL_W           = 12;
  localparam int SECTOR_W          = 32;
  localparam int SPC_W             = 8;
  localparam int PROD_W            = TOTAL_W + SPC_W;
  localparam int STEP_W            = 5;
  localparam int PROG_LEN          = 18;
  localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'hFFFFFFF;
  localparam logic [ENTRY_W-1:0] CHAIN_LIMIT  = 28'hFFFFFF8;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_TOTAL_CLUSTERS      = 2'd0;
  localparam logic [1:0] REG_DATA_START_SECTOR   = 2'd1;
  localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd2;

  // operation kinds
  typedef enum logic [1:0] {
    K_NEXT  = 2'd0,
    K_ALLOC = 2'd1,
    K_LINK  = 2'd2,
    K_FREE  = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_LONG  = 2'd3
  } status_t;

  // engine modes
  typedef enum logic [1:0] {
    CLEARING,
    IDLE,
    RUN
  } state_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_OUT_RANGE,
    C_RD_ZERO,
    C_CHAIN_END,
    C_CNT_LIMIT
  } cond_t;

  // cluster register operations
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_TWO,
    CUR_INC,
    CUR_RDATA
  } cur_op_t;

  // table write data select
  typedef enum logic [1:0] {
    W_NONE,
    W_LINK,
    W_EOC,
    W_ZERO
  } wsel_t;

  // result value select
  typedef enum logic [1:0] {
    V_CNT,
    V_RDATA,
    V_CUR
  } vsel_t;

  // one control word of the program
  typedef struct packed {
    cond_t              cond;
    logic [STEP_W-1:0]  target;
    logic               mem_rd;
    wsel_t              wsel;
    cur_op_t            cur_op;
    logic               cnt_inc;
    logic               mul;
    logic               fin;
    vsel_t              vsel;
    logic               sector;
    status_t            stat;
  } ucode_t;

  // program entry points and labels
  localparam logic [STEP_W-1:0] L_NEXT   = 5'd0;
  localparam logic [STEP_W-1:0] L_LINK   = 5'd2;
  localparam logic [STEP_W-1:0] L_ALLOC  = 5'd4;
  localparam logic [STEP_W-1:0] L_SCAN   = 5'd5;
  localparam logic [STEP_W-1:0] L_CLAIM  = 5'd8;
  localparam logic [STEP_W-1:0] L_FULL   = 5'd10;
  localparam logic [STEP_W-1:0] L_FREE   = 5'd11;
  localparam logic [STEP_W-1:0] L_RANGE  = 5'd15;
  localparam logic [STEP_W-1:0] L_LONG   = 5'd16;
  localparam logic [STEP_W-1:0] L_FDONE  = 5'd17;

  // microcode rom
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
    ucode_t cw;
    cw = '0;
    case (pc)
      // next: range check and read, then return the entry
      5'd0: begin
        cw.cond = C_OUT_RANGE; cw.target = L_RANGE; cw.mem_rd = 1'b1;
      end
      5'd1: begin
        cw.fin = 1'b1; cw.vsel = V_RDATA; cw.stat = STAT_OK;
      end
      // link: range check, then write
      5'd2: begin
        cw.cond = C_OUT_RANGE; cw.target = L_RANGE;
      end
      5'd3: begin
        cw.wsel = W_LINK; cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_OK;
      end
      // alloc: scan upward from cluster 2
      5'd4: begin
        cw.cur_op = CUR_TWO;
      end
      5'd5: begin
        cw.cond = C_OUT_RANGE; cw.target = L_FULL; cw.mem_rd = 1'b1;
      end
      5'd6: begin
        cw.cond = C_RD_ZERO; cw.target = L_CLAIM;
      end
      5'd7: begin
        cw.cur_op = CUR_INC; cw.cond = C_ALWAYS; cw.target = L_SCAN;
      end
      5'd8: begin
        cw.wsel = W_EOC; cw.mul = 1'b1;
      end
      5'd9: begin
        cw.fin = 1'b1; cw.vsel = V_CUR; cw.sector = 1'b1; cw.stat = STAT_OK;
      end
      5'd10: begin
        cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_FULL;
      end
      // free: walk the chain, zeroing each entry
      5'd11: begin
        cw.cond = C_CHAIN_END; cw.target = L_FDONE;
      end
      5'd12: begin
        cw.cond = C_OUT_RANGE; cw.target = L_RANGE;
      end
      5'd13: begin
        cw.cond = C_CNT_LIMIT; cw.target = L_LONG; cw.mem_rd = 1'b1;
      end
      5'd14: begin
        cw.wsel = W_ZERO; cw.cur_op = CUR_RDATA; cw.cnt_inc = 1'b1;
        cw.cond = C_ALWAYS; cw.target = L_FREE;
      end
      // endings: range error (shared by next, link and free), chain too long, free done
      5'd15: begin
        cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_RANGE;
      end
      5'd16: begin
        cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_LONG;
      end
      5'd17: begin
        cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_OK;
      end
      default: begin
        cw.fin = 1'b1; cw.vsel = V_CNT; cw.stat = STAT_OK;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> hw/rtl/fat_cluster_table_engine_unit.sv
// top level of the fat32 cluster table engine: sequencer, datapath and table memory
`timescale 1ns / 1ps
// The engine keeps a 28-bit cluster table in one single-port-write, registered-read
// memory and runs each operation as a short microcode program. After reset it sweeps
// the table to zero, one entry a cycle, and takes no beat until that is done
// (configuration writes are taken throughout). A next reads the entry and returns it,
// a link writes the link value, an alloc scans upward from cluster 2 and claims the
// first zero entry, and a free walks the chain zeroing each entry; every visited
// entry is used from the registered read port. One operation is in flight at a time; a
// finished result waits in the output register while the next operation is accepted.
module fat_cluster_table_engine_unit
  import fcte_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cluster [27:0], link_value [55:28]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // value [27:0], first_sector [59:28], zero [63:60]
  output logic [1:0]  m_tuser,   // status [1:0]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  // configuration registers
  logic [TOTAL_W-1:0]  total_clusters;
  logic [SECTOR_W-1:0] data_start_sector;
  logic [SPC_W-1:0]    sectors_per_cluster;

  // control
  state_t            state, state_next;
  logic [STEP_W-1:0] pc;
  logic [IDX_W-1:0]  clr;
  ucode_t            cw;
  logic              accept, advance, taken, in_rng;
  logic [STEP_W-1:0] entry;

  // datapath
  logic [ENTRY_W-1:0]  cur, lval, rdata;
  logic [TOTAL_W-1:0]  cnt;
  logic [PROD_W-1:0]   prod;
  logic [ENTRY_W-1:0]  out_value;
  logic [SECTOR_W-1:0] out_sector;
  status_t             out_status;
  logic [TOTAL_W:0]    last_clus;

  // table memory
  logic [ENTRY_W-1:0] fat_table [TABLE_ENTRIES];
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_clusters      <= TOTAL_W'(4094);
      data_start_sector   <= '0;
      sectors_per_cluster <= SPC_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_TOTAL_CLUSTERS:      total_clusters      <= pwdata[TOTAL_W-1:0];
        REG_DATA_START_SECTOR:   data_start_sector   <= pwdata;
        REG_SECTORS_PER_CLUSTER: sectors_per_cluster <= pwdata[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOTAL_CLUSTERS:      prdata = {{(32-TOTAL_W){1'b0}}, total_clusters};
      REG_DATA_START_SECTOR:   prdata = data_start_sector;
      REG_SECTORS_PER_CLUSTER: prdata = {{(32-SPC_W){1'b0}}, sectors_per_cluster};
      default:                 prdata = '0;
    endcase
  end

  // current control word and condition evaluation
  assign cw        = ucode_rom(pc);
  assign last_clus = {1'b0, total_clusters} + (TOTAL_W+1)'(1);
  assign in_rng    = (cur >= ENTRY_W'(2)) && (cur <= ENTRY_W'(last_clus)) &&
                     (cur < ENTRY_W'(TABLE_ENTRIES));

  always_comb begin
    case (cw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_OUT_RANGE: taken = !in_rng;
      C_RD_ZERO:   taken = (rdata == '0);
      C_CHAIN_END: taken = (cur == '0) || (cur >= CHAIN_LIMIT);
      C_CNT_LIMIT: taken = (cnt >= total_clusters);
      default:     taken = 1'b0;
    endcase
  end

  // program entry by kind
  always_comb begin
    case (kind_t'(s_tuser))
      K_NEXT:  entry = L_NEXT;
      K_ALLOC: entry = L_ALLOC;
      K_LINK:  entry = L_LINK;
      K_FREE:  entry = L_FREE;
      default: entry = L_NEXT;
    endcase
  end

  // a finishing step waits while the output register is still full
  assign advance  = (state == RUN) && !(cw.fin && m_tvalid && !m_tready);
  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEARING;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CLEARING: if (clr == IDX_W'(TABLE_ENTRIES - 1)) state_next = IDLE;
      IDLE:     if (accept) state_next = RUN;
      RUN:      if (advance && cw.fin) state_next = IDLE;
      default:  state_next = IDLE;
    endcase
  end

  // step counter and clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      clr <= '0;
    end else begin
      if (state == CLEARING) clr <= clr + IDX_W'(1);
      if (accept) begin
        pc <= entry;
      end else if (advance) begin
        pc <= taken ? cw.target : pc + STEP_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= s_tdata[27:0];
      lval <= s_tdata[55:28];
      cnt  <= '0;
    end else if (advance) begin
      case (cw.cur_op)
        CUR_HOLD:  cur <= cur;
        CUR_TWO:   cur <= ENTRY_W'(2);
        CUR_INC:   cur <= cur + ENTRY_W'(1);
        CUR_RDATA: cur <= rdata;
        default:   cur <= cur;
      endcase
      if (cw.cnt_inc) cnt <= cnt + TOTAL_W'(1);
      if (cw.mul) begin
        prod <= {{SPC_W{1'b0}}, cur[TOTAL_W-1:0] - TOTAL_W'(2)} *
                {{TOTAL_W{1'b0}}, sectors_per_cluster};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && cw.fin) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cw.fin) begin
      case (cw.vsel)
        V_CNT:   out_value <= ENTRY_W'(cnt);
        V_RDATA: out_value <= rdata;
        V_CUR:   out_value <= cur;
        default: out_value <= '0;
      endcase
      out_sector <= cw.sector ? data_start_sector + SECTOR_W'(prod) : '0;
      out_status <= cw.stat;
    end
  end

  assign m_tdata = {4'b0, out_sector, out_value};
  assign m_tuser = out_status;

  // table write port: clearing sweep or program write
  always_comb begin
    we    = 1'b0;
    waddr = cur[IDX_W-1:0];
    wdata = '0;
    if (state == CLEARING) begin
      we    = 1'b1;
      waddr = clr;
    end else if (advance) begin
      case (cw.wsel)
        W_NONE:  we = 1'b0;
        W_LINK:  begin we = 1'b1; wdata = lval; end
        W_EOC:   begin we = 1'b1; wdata = END_OF_CHAIN; end
        W_ZERO:  begin we = 1'b1; wdata = '0; end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) fat_table[waddr] <= wdata;
  end

  // registered table read
  always_ff @(posedge clk) begin
    if (advance && cw.mem_rd) rdata <= fat_table[cur[IDX_W-1:0]];
  end

  // freed count never passes the cluster count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (cnt <= total_clusters))
    else $error("free count passed total_clusters");

  // the step counter stays inside the program
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (pc < STEP_W'(PROG_LEN)))
    else $error("step counter outside program");

  // a finishing step hands over a result and frees the engine
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (advance && cw.fin) |=> (m_tvalid && (state == IDLE)))
    else $error("finished step did not present a result");

  // an accepted beat starts the program
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == RUN))
    else $error("accepted beat did not start the program");

endmodule
